@@ hdl/ntnh_pkg.sv @@
// Package for the neighbour table next-hop selection core.
// Holds the item and result word types and the fixed constants of the scan.
// No dependencies.
package ntnh_pkg;

	// Item modes.
	localparam logic MODE_RECEIVE = 1'b0;
	localparam logic MODE_FORWARD = 1'b1;

	// Starting value of the best RSSI during a forward scan.
	localparam logic signed [16:0] BEST_START = -17'sd1000;

	typedef struct packed {
		logic        mode;
		logic [15:0] sender_addr;
		logic [15:0] link_rssi;
		logic [7:0]  dest_low;
		logic [7:0]  prevhop_low;
	} item_t;

	typedef struct packed {
		logic        recorded;
		logic        hop_found;
		logic [15:0] next_hop_addr;
	} result_t;

endpackage

@@ hdl/neighbor_table_next_hop_select_core.sv @@
// Neighbour table with next-hop selection: top level and only module.
// Depends on ntnh_pkg for the item and result word types.
//
// Usage:
// One input channel (item_valid, item_stall, item) and one output channel
// (result_valid, result_stall, result). A word moves when valid is high and
// stall is low. Each input word gives exactly one result word.
// A receive word looks the sender up and updates its entry, or appends one
// if there is room; a forward word scans the table for a next hop by RSSI.
// The table lives in one synchronous memory of TABLE_DEPTH words with a
// registered read port; the scan reads one entry per cycle.
// A word is first scanned through the memory read port; in the final state
// a receive word's entry is written back and the result is loaded into the
// output register. A receive word that matches early ends its scan early,
// as does a forward word that finds its destination. One word is worked on
// at a time and the core passes back through its idle state between words,
// so no new word is taken before the last one is through.
// The result sits in an output register; the core accepts a new word while
// an earlier result waits, and holds a finished result until the register
// frees if the receiver keeps stalling.
// Reset empties the table at once (the entry count clears); no clearing pass.
module neighbor_table_next_hop_select_core
	import ntnh_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	item_t  item_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pend_idx_s1;

	logic                    found_q;
	logic [IDX_W-1:0]        pos_q;
	logic                    have_q;
	logic [15:0]             pick_q;
	logic signed [16:0]      best_q;

	logic [31:0] entry_mem [TABLE_DEPTH];
	logic [31:0] rd_data_s1;
	logic        wr_en;
	logic [IDX_W-1:0] wr_idx;

	// Scan step, evaluated on the entry whose read data has just returned.
	logic                found_d;
	logic [IDX_W-1:0]    pos_d;
	logic                have_d;
	logic [15:0]         pick_d;
	logic signed [16:0]  best_d;
	logic                stop;
	logic                issue;
	logic                scan_end;
	logic                slot_free;
	logic                table_full;
	logic [15:0]         ent_addr;
	logic signed [16:0]  ent_rssi;
	logic [7:0]          ent_low;

	assign ent_addr = rd_data_s1[31:16];
	assign ent_rssi = $signed({1'b0, rd_data_s1[15:0]});
	assign ent_low  = rd_data_s1[23:16];

	always_comb begin
		found_d = found_q;
		pos_d   = pos_q;
		have_d  = have_q;
		pick_d  = pick_q;
		best_d  = best_q;
		stop    = 1'b0;
		if (pend_s1) begin
			if (item_q.mode == MODE_RECEIVE) begin
				if (ent_addr == item_q.sender_addr) begin
					found_d = 1'b1;
					pos_d   = pend_idx_s1;
					stop    = 1'b1;
				end
			end else begin
				// A lone entry is the default choice.
				if (count_q == CNT_W'(1) && pend_idx_s1 == '0) begin
					have_d = 1'b1;
					pick_d = ent_addr;
				end
				if (ent_rssi != best_q) begin
					if (ent_rssi > best_q && ent_low != item_q.prevhop_low) begin
						have_d = 1'b1;
						pick_d = ent_addr;
						best_d = ent_rssi;
					end
					if (ent_low == item_q.dest_low) begin
						have_d = 1'b1;
						pick_d = ent_addr;
						stop   = 1'b1;
					end
				end
			end
		end
	end

	assign issue      = (state_q == S_SCAN) && !stop && (rd_idx_q < count_q);
	assign scan_end   = stop || (rd_idx_q == count_q);
	assign slot_free  = !result_valid || !result_stall;
	assign table_full = (count_q >= CNT_W'(TABLE_DEPTH));
	assign item_stall = (state_q != S_IDLE);

	assign wr_en  = (state_q == S_FIN) && slot_free && (item_q.mode == MODE_RECEIVE)
		&& (found_q || !table_full);
	assign wr_idx = found_q ? pos_q : count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_idx] <= {item_q.sender_addr, item_q.link_rssi};
		end
		rd_data_s1 <= entry_mem[rd_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			pend_s1      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (state_q == S_FIN && slot_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			pend_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (item_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						if (item_q.mode == MODE_RECEIVE && !found_q && !table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		pend_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == S_IDLE && item_valid) begin
			item_q  <= item;
			found_q <= 1'b0;
			pos_q   <= '0;
			have_q  <= 1'b0;
			pick_q  <= '0;
			best_q  <= BEST_START;
		end else if (state_q == S_SCAN) begin
			found_q <= found_d;
			pos_q   <= pos_d;
			have_q  <= have_d;
			pick_q  <= pick_d;
			best_q  <= best_d;
		end
		if (state_q == S_FIN && slot_free) begin
			if (item_q.mode == MODE_RECEIVE) begin
				result.recorded      <= found_q || !table_full;
				result.hop_found     <= 1'b0;
				result.next_hop_addr <= '0;
			end else begin
				result.recorded      <= 1'b0;
				result.hop_found     <= have_q;
				result.next_hop_addr <= have_q ? pick_q : 16'h0000;
			end
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for neighbor_table_next_hop_select_core: directed and random words with
// a self-checking table predictor. Depends on ntnh_pkg and the core's top level only.
module testbench;
	import ntnh_pkg::*;

	localparam int TABLE_DEPTH = 16;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Predicted table contents, kept in insertion order like the core's.
	logic [15:0] tbl_addr [TABLE_DEPTH];
	logic [15:0] tbl_rssi [TABLE_DEPTH];
	int          tbl_count;

	result_t hop_expect_q [$];
	int      n_errors;
	int      idle_pct;
	int      stall_pct;

	neighbor_table_next_hop_select_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	// Works out the result of one word and updates the predicted table.
	function automatic result_t predict_next_hop(input item_t w);
		result_t r;
		int      k;
		int      pos;
		int      best;
		int      rv;
		bit      have;
		int      pick;
		r = '0;
		if (w.mode == MODE_RECEIVE) begin
			pos = -1;
			for (k = 0; k < tbl_count; k++) begin
				if (pos < 0 && tbl_addr[k] == w.sender_addr)
					pos = k;
			end
			if (pos < 0) begin
				if (tbl_count >= TABLE_DEPTH)
					return r;
				pos = tbl_count;
				tbl_addr[pos] = w.sender_addr;
				tbl_count++;
			end
			tbl_rssi[pos] = w.link_rssi;
			r.recorded = 1'b1;
		end else begin
			best = int'(BEST_START);
			have = 1'b0;
			pick = 0;
			// A lone neighbour is the default choice even if it is the previous hop.
			if (tbl_count == 1)
				have = 1'b1;
			for (k = 0; k < tbl_count; k++) begin
				rv = int'(tbl_rssi[k]);
				// An entry whose RSSI ties the best so far is passed over completely.
				if (rv != best) begin
					if (rv > best && tbl_addr[k][7:0] != w.prevhop_low) begin
						have = 1'b1;
						pick = k;
						best = rv;
					end
					if (tbl_addr[k][7:0] == w.dest_low) begin
						have = 1'b1;
						pick = k;
						break;
					end
				end
			end
			r.hop_found = have;
			r.next_hop_addr = have ? tbl_addr[pick] : 16'h0000;
		end
		return r;
	endfunction

	function automatic item_t receive_word(input logic [15:0] addr, input logic [15:0] rssi);
		item_t w;
		w.mode = MODE_RECEIVE;
		w.sender_addr = addr;
		w.link_rssi = rssi;
		w.dest_low = 8'($urandom);
		w.prevhop_low = 8'($urandom);
		return w;
	endfunction

	function automatic item_t forward_word(input logic [7:0] dest, input logic [7:0] prev);
		item_t w;
		w.mode = MODE_FORWARD;
		w.sender_addr = 16'($urandom);
		w.link_rssi = 16'($urandom);
		w.dest_low = dest;
		w.prevhop_low = prev;
		return w;
	endfunction

	function automatic logic [15:0] fresh_addr();
		logic [15:0] a;
		bit          known;
		int          k;
		do begin
			a = 16'($urandom);
			known = 1'b0;
			for (k = 0; k < tbl_count; k++)
				if (tbl_addr[k] == a)
					known = 1'b1;
		end while (known);
		return a;
	endfunction

	// Random word biased towards known addresses, shared low bytes and tied RSSI values.
	// new_odds is one in how many receive words carries an address from outside the table.
	function automatic item_t random_word(input int new_odds);
		item_t w;
		int    k;
		int    j;
		k = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
		j = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
		w.mode = 1'($urandom_range(0, 1));
		w.sender_addr = 16'($urandom);
		w.link_rssi = 16'($urandom);
		w.dest_low = 8'($urandom);
		w.prevhop_low = 8'($urandom);
		if (w.mode == MODE_RECEIVE) begin
			if (tbl_count > 0 && $urandom_range(1, new_odds) != 1)
				w.sender_addr = tbl_addr[k];
			else if ($urandom_range(0, 1))
				w.sender_addr[7:0] = tbl_addr[k][7:0];
			case ($urandom_range(0, 3))
				0: w.link_rssi = tbl_rssi[j];
				1: w.link_rssi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				2: w.link_rssi = 16'($urandom_range(0, 15));
				default: ;
			endcase
		end else begin
			if ($urandom_range(0, 1))
				w.dest_low = tbl_addr[k][7:0];
			if ($urandom_range(0, 1))
				w.prevhop_low = tbl_addr[j][7:0];
		end
		return w;
	endfunction

	// Offers one word, with random idle cycles first, and predicts it once accepted.
	task automatic send_word(input item_t w);
		if ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
		item_valid <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (item_stall);
		hop_expect_q.push_back(predict_next_hop(w));
	endtask

	// The sender holds off until every predicted result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (hop_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int n_words, input int new_odds);
		int i;
		for (i = 0; i < n_words; i++)
			send_word(random_word(new_odds));
		drain_results();
	endtask

	task automatic test_small_table();
		idle_pct = 0;
		stall_pct = 0;
		send_word(forward_word(8'h00, 8'h00));
		send_word(receive_word(16'h0000, 16'h0000));
		send_word(forward_word(8'h55, 8'h00));
		send_word(receive_word(16'h0000, 16'hFFFF));
		send_word(receive_word(16'hFFFF, 16'hFFFF));
		send_word(forward_word(8'hFF, 8'hAA));
		send_word(forward_word(8'hFF, 8'h00));
		send_word(receive_word(16'h12AB, 16'h8000));
		send_word(forward_word(8'h00, 8'hAB));
		send_word(forward_word(8'h34, 8'hFF));
		send_word(receive_word(16'h5500, 16'h0001));
		send_word(forward_word(8'h00, 8'h00));
		drain_results();
	endtask

	task automatic test_table_growth();
		idle_pct = 0;
		stall_pct = 0;
		run_random(400, 25);
	endtask

	task automatic test_full_table();
		while (tbl_count < TABLE_DEPTH)
			send_word(receive_word(fresh_addr(), 16'($urandom)));
		send_word(receive_word(fresh_addr(), 16'($urandom)));
		send_word(receive_word(tbl_addr[TABLE_DEPTH - 1], tbl_rssi[0]));
		send_word(forward_word(tbl_addr[TABLE_DEPTH - 1][7:0], tbl_addr[0][7:0]));
		send_word(forward_word(8'($urandom), 8'($urandom)));
		drain_results();
	endtask

	task automatic test_sender_gaps();
		idle_pct = 54;
		stall_pct = 0;
		run_random(400, 5);
	endtask

	task automatic test_receiver_stalls();
		idle_pct = 0;
		stall_pct = 54;
		run_random(400, 5);
	endtask

	task automatic test_both_pausing();
		idle_pct = 9;
		stall_pct = 9;
		run_random(400, 5);
	endtask

	task automatic report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (hop_expect_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got %h", $time, result);
				n_errors++;
			end else begin
				want = hop_expect_q.pop_front();
				report_field("recorded", want.recorded, result.recorded);
				report_field("hop_found", want.hop_found, result.hop_found);
				report_field("next_hop_addr", want.next_hop_addr, result.next_hop_addr);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		n_errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		tbl_count = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			tbl_addr[k] = '0;
			tbl_rssi[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_table();
		test_table_growth();
		test_full_table();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_pausing();

		// Leave room for any stray word after the last expected one.
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ neighbor_table_next_hop_select_core.f @@
hdl/ntnh_pkg.sv
hdl/neighbor_table_next_hop_select_core.sv
tb/testbench.sv
